// ===== src/hsv2rgb_pkg.sv =====
// Shared types and constants for the HSV to RGB converter pipeline.
// Depends on nothing; every other file in src imports this package.
package hsv2rgb_pkg;

    // Default channel width for saturation, brightness and the color outputs.
    localparam int CHANNEL_BITS_DEF = 8;

    // Hue arrives in 1/16 degree steps: a full turn is 5760, a sector is 960.
    localparam int HUE_W    = 13;
    localparam int REM_W    = 10;
    localparam int SECTOR_W = 3;

    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 13'd5760;
    localparam logic [HUE_W-1:0] HUE_SECTOR    = 13'd960;
    localparam logic [REM_W-1:0] SECTOR_SPAN   = 10'd960;
    localparam logic [REM_W-1:0] SECTOR_HALF   = 10'd480;

    // Rounded division by 960 is done as a shift by 6 followed by a
    // reciprocal multiply for the remaining factor of 15. The reciprocal is
    // ceil(2^23 / 15); it is exact for shifted values below 2^20.
    localparam int               FRAC_SHIFT  = 6;
    localparam int               RECIP_SHIFT = 23;
    localparam int               RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_15  = 20'd559241;

    // Hue sectors of 60 degrees each.
    localparam logic [SECTOR_W-1:0] SECT_RED     = 3'd0;
    localparam logic [SECTOR_W-1:0] SECT_YELLOW  = 3'd1;
    localparam logic [SECTOR_W-1:0] SECT_GREEN   = 3'd2;
    localparam logic [SECTOR_W-1:0] SECT_CYAN    = 3'd3;
    localparam logic [SECTOR_W-1:0] SECT_BLUE    = 3'd4;
    localparam logic [SECTOR_W-1:0] SECT_MAGENTA = 3'd5;

    // Load enables for the five pipeline registers.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

    // Hue at which a sector starts.
    function automatic logic [HUE_W-1:0] sector_base(input logic [SECTOR_W-1:0] sector);
        logic [HUE_W-1:0] base;
        case (sector)
            SECT_RED:     base = 13'd0;
            SECT_YELLOW:  base = 13'd960;
            SECT_GREEN:   base = 13'd1920;
            SECT_CYAN:    base = 13'd2880;
            SECT_BLUE:    base = 13'd3840;
            SECT_MAGENTA: base = 13'd4800;
            default:      base = 13'd0;
        endcase
        return base;
    endfunction

endpackage

// ===== src/hsv2rgb_hue_stage.sv =====
// First pipeline stage: wraps the hue and splits it into sector and remainder.
// Depends on hsv2rgb_pkg.
module hsv2rgb_hue_stage #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  hsv2rgb_pkg::t_pipe_en             i_en,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]     i_hue,
    input  logic [CHANNEL_BITS-1:0]           i_saturation,
    input  logic [CHANNEL_BITS-1:0]           i_brightness,
    output logic [hsv2rgb_pkg::SECTOR_W-1:0]  o_sector,
    output logic [hsv2rgb_pkg::REM_W-1:0]     o_rem,
    output logic [CHANNEL_BITS-1:0]           o_saturation,
    output logic [CHANNEL_BITS-1:0]           o_brightness
);
    import hsv2rgb_pkg::*;

    logic [HUE_W-1:0]    hue_wrap;
    logic [HUE_W-1:0]    rem_full;
    logic [SECTOR_W-1:0] n_sector;
    logic [SECTOR_W-1:0] r_sector;
    logic [REM_W-1:0]    r_rem;
    logic [CHANNEL_BITS-1:0] r_sat;
    logic [CHANNEL_BITS-1:0] r_bright;

    // A full turn or more counts as zero; the sector is found by comparing
    // against the five sector boundaries in parallel.
    always_comb begin
        hue_wrap = (i_hue >= HUE_FULL_TURN) ? '0 : i_hue;
        n_sector = SECT_RED;
        if (hue_wrap >= sector_base(SECT_YELLOW)) begin
            n_sector = SECT_YELLOW;
        end
        if (hue_wrap >= sector_base(SECT_GREEN)) begin
            n_sector = SECT_GREEN;
        end
        if (hue_wrap >= sector_base(SECT_CYAN)) begin
            n_sector = SECT_CYAN;
        end
        if (hue_wrap >= sector_base(SECT_BLUE)) begin
            n_sector = SECT_BLUE;
        end
        if (hue_wrap >= sector_base(SECT_MAGENTA)) begin
            n_sector = SECT_MAGENTA;
        end
        rem_full = hue_wrap - sector_base(n_sector);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_sector <= n_sector;
            r_rem    <= rem_full[REM_W-1:0];
            r_sat    <= i_saturation;
            r_bright <= i_brightness;
        end
    end

    assign o_sector     = r_sector;
    assign o_rem        = r_rem;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule

// ===== src/hsv2rgb_frac_stages.sv =====
// Stages two to four: saturation products, rounded scaling by 1/960, and the
// brightness products for q and t. Depends on hsv2rgb_pkg.
module hsv2rgb_frac_stages #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  hsv2rgb_pkg::t_pipe_en             i_en,
    input  logic [hsv2rgb_pkg::SECTOR_W-1:0]  i_sector,
    input  logic [hsv2rgb_pkg::REM_W-1:0]     i_rem,
    input  logic [CHANNEL_BITS-1:0]           i_saturation,
    input  logic [CHANNEL_BITS-1:0]           i_brightness,
    output logic [hsv2rgb_pkg::SECTOR_W-1:0]  o_sector,
    output logic [CHANNEL_BITS-1:0]           o_brightness,
    output logic [2*CHANNEL_BITS-1:0]         o_prod_p,
    output logic [2*CHANNEL_BITS-1:0]         o_prod_q,
    output logic [2*CHANNEL_BITS-1:0]         o_prod_t
);
    import hsv2rgb_pkg::*;

    localparam int PS_W = CHANNEL_BITS + REM_W;
    localparam int Z_W  = PS_W - FRAC_SHIFT;
    localparam int M_W  = Z_W + RECIP_W;
    localparam int PP_W = 2 * CHANNEL_BITS;
    localparam logic [CHANNEL_BITS-1:0] FULL_SCALE = '1;

    // Stage two registers.
    logic [PS_W-1:0]         r2_ps;
    logic [PS_W-1:0]         r2_pq;
    logic [PP_W-1:0]         r2_pp;
    logic [CHANNEL_BITS-1:0] r2_bright;
    logic [SECTOR_W-1:0]     r2_sector;
    // Stage three registers.
    logic [M_W-1:0]          r3_ms;
    logic [M_W-1:0]          r3_mq;
    logic [PP_W-1:0]         r3_pp;
    logic [CHANNEL_BITS-1:0] r3_bright;
    logic [SECTOR_W-1:0]     r3_sector;
    // Stage four registers.
    logic [PP_W-1:0]         r4_pq;
    logic [PP_W-1:0]         r4_pt;
    logic [PP_W-1:0]         r4_pp;
    logic [CHANNEL_BITS-1:0] r4_bright;
    logic [SECTOR_W-1:0]     r4_sector;

    logic [REM_W-1:0]        rem_rest;
    logic [PS_W-1:0]         ps_round;
    logic [PS_W-1:0]         pq_round;
    logic [Z_W-1:0]          z_s;
    logic [Z_W-1:0]          z_q;
    logic [CHANNEL_BITS-1:0] sp;
    logic [CHANNEL_BITS-1:0] sq;

    always_comb begin
        rem_rest = SECTOR_SPAN - i_rem;
        // Adding half of 960 before the shift gives round-half-up.
        ps_round = r2_ps + PS_W'(SECTOR_HALF);
        pq_round = r2_pq + PS_W'(SECTOR_HALF);
        z_s      = ps_round[PS_W-1:FRAC_SHIFT];
        z_q      = pq_round[PS_W-1:FRAC_SHIFT];
        // The scaled saturation terms never exceed full scale.
        sp       = r3_ms[RECIP_SHIFT +: CHANNEL_BITS];
        sq       = r3_mq[RECIP_SHIFT +: CHANNEL_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_ps     <= PS_W'(i_saturation) * PS_W'(i_rem);
            r2_pq     <= PS_W'(i_saturation) * PS_W'(rem_rest);
            r2_pp     <= PP_W'(i_brightness) * PP_W'(FULL_SCALE - i_saturation);
            r2_bright <= i_brightness;
            r2_sector <= i_sector;
        end
        if (i_en.s3) begin
            r3_ms     <= M_W'(z_s) * M_W'(RECIP_15);
            r3_mq     <= M_W'(z_q) * M_W'(RECIP_15);
            r3_pp     <= r2_pp;
            r3_bright <= r2_bright;
            r3_sector <= r2_sector;
        end
        if (i_en.s4) begin
            r4_pq     <= PP_W'(r3_bright) * PP_W'(FULL_SCALE - sp);
            r4_pt     <= PP_W'(r3_bright) * PP_W'(FULL_SCALE - sq);
            r4_pp     <= r3_pp;
            r4_bright <= r3_bright;
            r4_sector <= r3_sector;
        end
    end

    assign o_sector     = r4_sector;
    assign o_brightness = r4_bright;
    assign o_prod_p     = r4_pp;
    assign o_prod_q     = r4_pq;
    assign o_prod_t     = r4_pt;

endmodule

// ===== src/hsv2rgb_out_stage.sv =====
// Last stage: rounded division of p, q and t by full scale, channel routing
// by sector, and the output register. Depends on hsv2rgb_pkg.
module hsv2rgb_out_stage #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  hsv2rgb_pkg::t_pipe_en             i_en,
    input  logic [hsv2rgb_pkg::SECTOR_W-1:0]  i_sector,
    input  logic [CHANNEL_BITS-1:0]           i_brightness,
    input  logic [2*CHANNEL_BITS-1:0]         i_prod_p,
    input  logic [2*CHANNEL_BITS-1:0]         i_prod_q,
    input  logic [2*CHANNEL_BITS-1:0]         i_prod_t,
    output logic [CHANNEL_BITS-1:0]           o_red,
    output logic [CHANNEL_BITS-1:0]           o_green,
    output logic [CHANNEL_BITS-1:0]           o_blue
);
    import hsv2rgb_pkg::*;

    localparam int PP_W = 2 * CHANNEL_BITS;
    localparam logic [CHANNEL_BITS:0] FS_X  = {1'b0, {CHANNEL_BITS{1'b1}}};
    localparam logic [CHANNEL_BITS:0] FS_X2 = {FS_X[CHANNEL_BITS-1:0], 1'b0};
    localparam logic [PP_W-1:0]       HALF  = PP_W'((1 << (CHANNEL_BITS - 1)) - 1);

    // Rounded division by 2^N - 1. With y = hi * 2^N + lo, y equals
    // hi * (2^N - 1) + (hi + lo), and hi + lo stays at or below twice the
    // divisor, so two compares finish the quotient.
    function automatic logic [CHANNEL_BITS-1:0] div_full(input logic [PP_W-1:0] prod);
        logic [PP_W-1:0]       y;
        logic [CHANNEL_BITS:0] q0;
        logic [CHANNEL_BITS:0] lo_sum;
        logic [CHANNEL_BITS:0] quo;
        y      = prod + HALF;
        q0     = {1'b0, y[PP_W-1:CHANNEL_BITS]};
        lo_sum = {1'b0, y[CHANNEL_BITS-1:0]} + q0;
        quo    = q0;
        if (lo_sum >= FS_X) begin
            quo = quo + (CHANNEL_BITS+1)'(1);
        end
        if (lo_sum >= FS_X2) begin
            quo = quo + (CHANNEL_BITS+1)'(1);
        end
        return quo[CHANNEL_BITS-1:0];
    endfunction

    logic [CHANNEL_BITS-1:0] p_val;
    logic [CHANNEL_BITS-1:0] q_val;
    logic [CHANNEL_BITS-1:0] t_val;
    logic [CHANNEL_BITS-1:0] n_red;
    logic [CHANNEL_BITS-1:0] n_green;
    logic [CHANNEL_BITS-1:0] n_blue;
    logic [CHANNEL_BITS-1:0] r_red;
    logic [CHANNEL_BITS-1:0] r_green;
    logic [CHANNEL_BITS-1:0] r_blue;

    always_comb begin
        p_val = div_full(i_prod_p);
        q_val = div_full(i_prod_q);
        t_val = div_full(i_prod_t);
        case (i_sector)
            SECT_RED: begin
                n_red = i_brightness; n_green = t_val;        n_blue = p_val;
            end
            SECT_YELLOW: begin
                n_red = q_val;        n_green = i_brightness; n_blue = p_val;
            end
            SECT_GREEN: begin
                n_red = p_val;        n_green = i_brightness; n_blue = t_val;
            end
            SECT_CYAN: begin
                n_red = p_val;        n_green = q_val;        n_blue = i_brightness;
            end
            SECT_BLUE: begin
                n_red = t_val;        n_green = p_val;        n_blue = i_brightness;
            end
            default: begin
                n_red = i_brightness; n_green = p_val;        n_blue = q_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ===== src/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: pipeline valid tracking and stalls.
// Depends on hsv2rgb_pkg, hsv2rgb_hue_stage, hsv2rgb_frac_stages, hsv2rgb_out_stage.
//
// This block turns one HSV pixel word into one RGB word. Hue is in 1/16 degree
// steps (a hue of 5760 or more acts as zero); saturation, brightness and the
// three color channels are CHANNEL_BITS-wide fractions where all ones means
// 1.0. Every division (by 960 for the hue fraction, by full scale for p, q and
// t) rounds half up. A zero saturation needs no special path: p, q and t all
// come out equal to the brightness, which gives gray. The datapath is a
// five-stage pipeline (hue split, saturation products, scaling by 1/960,
// brightness products, final division and channel routing), so the result
// word passes through the stage registers in that order and is presented by
// the output register; one word can be accepted on every clock while no
// stall has filled every stage. Each stage loads whenever it is empty or the
// stage after it moves, so a stall at the output only holds up the input
// once every stage is full, and empty slots are squeezed out while the output
// waits. Both channels use valid/ready; the input channel's o_ready is a
// combinational function of the stage valid bits and i_ready.
module hsv_to_rgb_converter #(
    parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]     i_hue,
    input  logic [CHANNEL_BITS-1:0]           i_saturation,
    input  logic [CHANNEL_BITS-1:0]           i_brightness,
    // Output channel.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [CHANNEL_BITS-1:0]           o_red,
    output logic [CHANNEL_BITS-1:0]           o_green,
    output logic [CHANNEL_BITS-1:0]           o_blue
);
    import hsv2rgb_pkg::*;

    localparam int N_STAGES = 5;

    // One valid bit per pipeline register; the last one is the output word.
    logic [N_STAGES-1:0] r_valid;
    logic [N_STAGES-1:0] n_valid;
    logic [N_STAGES-1:0] stage_en;
    t_pipe_en            pipe_en;

    logic [SECTOR_W-1:0]     s1_sector;
    logic [REM_W-1:0]        s1_rem;
    logic [CHANNEL_BITS-1:0] s1_sat;
    logic [CHANNEL_BITS-1:0] s1_bright;
    logic [SECTOR_W-1:0]     s4_sector;
    logic [CHANNEL_BITS-1:0] s4_bright;
    logic [2*CHANNEL_BITS-1:0] s4_prod_p;
    logic [2*CHANNEL_BITS-1:0] s4_prod_q;
    logic [2*CHANNEL_BITS-1:0] s4_prod_t;

    // A stage loads when it holds nothing or its contents move on. The chain
    // runs from the output back to the input.
    always_comb begin
        stage_en[N_STAGES-1] = !r_valid[N_STAGES-1] || i_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
        n_valid[0] = stage_en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < N_STAGES; k++) begin
            n_valid[k] = stage_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    assign pipe_en = '{s1: stage_en[0], s2: stage_en[1], s3: stage_en[2],
                       s4: stage_en[3], s5: stage_en[4]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = stage_en[0];
    assign o_valid = r_valid[N_STAGES-1];

    hsv2rgb_hue_stage #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_hue_stage (
        .i_clk        (i_clk),
        .i_en         (pipe_en),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_sector     (s1_sector),
        .o_rem        (s1_rem),
        .o_saturation (s1_sat),
        .o_brightness (s1_bright)
    );

    hsv2rgb_frac_stages #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_frac_stages (
        .i_clk        (i_clk),
        .i_en         (pipe_en),
        .i_sector     (s1_sector),
        .i_rem        (s1_rem),
        .i_saturation (s1_sat),
        .i_brightness (s1_bright),
        .o_sector     (s4_sector),
        .o_brightness (s4_bright),
        .o_prod_p     (s4_prod_p),
        .o_prod_q     (s4_prod_q),
        .o_prod_t     (s4_prod_t)
    );

    hsv2rgb_out_stage #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_out_stage (
        .i_clk        (i_clk),
        .i_en         (pipe_en),
        .i_sector     (s4_sector),
        .i_brightness (s4_bright),
        .i_prod_p     (s4_prod_p),
        .i_prod_q     (s4_prod_q),
        .i_prod_t     (s4_prod_t),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

endmodule

// ===== test/tb_hsv_to_rgb_converter.sv =====
// Self-checking testbench for hsv_to_rgb_converter: pixel words in, RGB words out.
// Depends on hsv2rgb_pkg and the converter RTL; a small tracker class predicts and checks.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;
    import hsv2rgb_pkg::*;

    localparam int CB        = CHANNEL_BITS_DEF;
    localparam int CHAN_FULL = (1 << CB) - 1;
    // Generous bound for about 800 words, even at the slowest idle mix.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_PER_PHASE = 250;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } t_rgb;

    // The tracker holds one predicted RGB word for every accepted HSV word, in order.
    class rgb_tracker;
        t_rgb expected_rgb[$];
        int   mismatches;
        int   checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        // Rounded division, halves go up.
        static function int unsigned div_round(int unsigned num, int unsigned den);
            return (num + den / 2) / den;
        endfunction

        // Fixed-point HSV to RGB conversion, channel by channel.
        static function t_rgb predict_rgb(int unsigned h, int unsigned s, int unsigned v);
            int unsigned      rem;
            int unsigned      sp;
            int unsigned      sq;
            int unsigned      p;
            int unsigned      q;
            int unsigned      t;
            logic [SECTOR_W-1:0] sector;
            t_rgb             c;
            if (s == 0) begin
                c = '{v[CB-1:0], v[CB-1:0], v[CB-1:0]};
            end else begin
                // A full turn or more wraps to red.
                if (h >= HUE_FULL_TURN) begin
                    h = 0;
                end
                sector = SECTOR_W'(h / HUE_SECTOR);
                rem    = h % HUE_SECTOR;
                sp = div_round(s * rem, HUE_SECTOR);
                sq = div_round(s * (HUE_SECTOR - rem), HUE_SECTOR);
                p  = div_round(v * (CHAN_FULL - s), CHAN_FULL);
                q  = div_round(v * (CHAN_FULL - sp), CHAN_FULL);
                t  = div_round(v * (CHAN_FULL - sq), CHAN_FULL);
                case (sector)
                    SECT_RED:     c = '{v[CB-1:0], t[CB-1:0], p[CB-1:0]};
                    SECT_YELLOW:  c = '{q[CB-1:0], v[CB-1:0], p[CB-1:0]};
                    SECT_GREEN:   c = '{p[CB-1:0], v[CB-1:0], t[CB-1:0]};
                    SECT_CYAN:    c = '{p[CB-1:0], q[CB-1:0], v[CB-1:0]};
                    SECT_BLUE:    c = '{t[CB-1:0], p[CB-1:0], v[CB-1:0]};
                    default:      c = '{v[CB-1:0], p[CB-1:0], q[CB-1:0]};
                endcase
            end
            return c;
        endfunction

        // The prediction goes to the tail of the queue.
        function void note_pixel(int unsigned h, int unsigned s, int unsigned v);
            expected_rgb.insert(expected_rgb.size(), predict_rgb(h, s, v));
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

        task report_mismatch(string what, t_rgb got, t_rgb want);
            $display("MISMATCH %s: got r=%0d g=%0d b=%0d, expected r=%0d g=%0d b=%0d",
                     what, got.red, got.green, got.blue, want.red, want.green, want.blue);
            mismatches++;
        endtask

        task check_pixel(t_rgb got);
            t_rgb want;
            if (expected_rgb.size() == 0) begin
                report_mismatch("output word with nothing pending", got, '0);
            end else begin
                want = expected_rgb.pop_front();
                checked++;
                if (got.red !== want.red) begin
                    report_mismatch("red", got, want);
                end
                if (got.green !== want.green) begin
                    report_mismatch("green", got, want);
                end
                if (got.blue !== want.blue) begin
                    report_mismatch("blue", got, want);
                end
            end
        endtask
    endclass

    // Every input of the converter starts at a known value.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [HUE_W-1:0]    i_hue = '0;
    logic [CB-1:0]       i_saturation = '0;
    logic [CB-1:0]       i_brightness = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [CB-1:0]       o_red;
    logic [CB-1:0]       o_green;
    logic [CB-1:0]       o_blue;

    rgb_tracker tracker;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         cycles = 0;
    int         sent = 0;
    int         directed_count = 0;

    hsv_to_rgb_converter #(.CHANNEL_BITS(CB)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter with a hard stop in case the pipeline hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words pending.",
                     cycles, tracker.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: values are sampled at the edge, before this edge's updates land,
    // so a word counts as delivered exactly when o_valid and i_ready were both high.
    // The ready for the next cycle is then chosen at random from the current mix.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_pixel('{o_red, o_green, o_blue});
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one HSV word, idling first at the current sender rate. The caller is always
    // at a rising edge, so each signal gets one nonblocking update per time step: after
    // acceptance the next call either drops valid or presents the next word directly.
    task automatic send_pixel(input int unsigned h, input int unsigned s, input int unsigned v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= HUE_W'(h);
        i_saturation <= CB'(s);
        i_brightness <= CB'(v);
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        // Accepted at this edge; the first result cannot appear before the next one.
        tracker.note_pixel(h, s, v);
        sent++;
    endtask

    // Random word: hues mostly inside a turn, some at sector edges and some past a full
    // turn; saturation and brightness lean on zero and full scale now and then.
    task automatic send_random_pixel();
        int unsigned h;
        int unsigned s;
        int unsigned v;
        case ($urandom_range(9))
            0, 1:    h = $urandom_range((1 << HUE_W) - 1);
            2:       h = (HUE_SECTOR * $urandom_range(6) + $urandom_range(2)
                          + (1 << HUE_W) - 1) % (1 << HUE_W);
            default: h = $urandom_range(HUE_FULL_TURN - 1);
        endcase
        case ($urandom_range(9))
            0:       s = 0;
            1:       s = CHAN_FULL;
            default: s = $urandom_range(CHAN_FULL);
        endcase
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = CHAN_FULL;
            default: v = $urandom_range(CHAN_FULL);
        endcase
        send_pixel(h, s, v);
    endtask

    initial begin
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles lightly, receiver stalls most of the time.
        send_idle_pct = 28;
        recv_idle_pct = 81;

        // Directed words: one inside every sector, the sector edges, the last hue of a
        // turn, a full turn and the largest hue (both wrap to red), gray from zero
        // saturation, and zero and full-scale saturation and brightness.
        send_pixel(0, CHAN_FULL, CHAN_FULL);
        send_pixel(480, CHAN_FULL, CHAN_FULL);
        send_pixel(HUE_SECTOR - 1, CHAN_FULL, CHAN_FULL);
        send_pixel(HUE_SECTOR, CHAN_FULL, CHAN_FULL);
        send_pixel(1440, 200, 180);
        send_pixel(2 * HUE_SECTOR, CHAN_FULL, 128);
        send_pixel(2400, 128, 255);
        send_pixel(3 * HUE_SECTOR, 77, 200);
        send_pixel(3360, 255, 1);
        send_pixel(4 * HUE_SECTOR, 160, 99);
        send_pixel(4320, 1, 255);
        send_pixel(5 * HUE_SECTOR, 255, 255);
        send_pixel(5280, 100, 250);
        send_pixel(HUE_FULL_TURN - 1, CHAN_FULL, CHAN_FULL);
        send_pixel(HUE_FULL_TURN, CHAN_FULL, CHAN_FULL);
        send_pixel((1 << HUE_W) - 1, 170, 85);
        send_pixel(2000, 0, 0);
        send_pixel(4000, 0, CHAN_FULL);
        send_pixel((1 << HUE_W) - 1, 0, 123);
        send_pixel(1234, CHAN_FULL, 0);
        send_pixel(0, 0, 0);
        send_pixel(3000, 1, 1);
        directed_count = sent;

        repeat (RANDOM_PER_PHASE) send_random_pixel();

        // Phase two: the roles swap.
        send_idle_pct = 81;
        recv_idle_pct = 28;
        repeat (RANDOM_PER_PHASE) send_random_pixel();

        // Phase three: full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_pixel();
        i_valid <= 1'b0;

        // Let the pipeline drain, then allow a few more cycles for stray output words.
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixel words (%0d directed, the rest random) under three idle mixes;",
                 sent, directed_count);
        $display("checked %0d RGB words, %0d mismatches, %0d cycles.",
                 tracker.checked, tracker.mismatches, cycles);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/hsv2rgb_pkg.sv
src/hsv2rgb_hue_stage.sv
src/hsv2rgb_frac_stages.sv
src/hsv2rgb_out_stage.sv
src/hsv_to_rgb_converter.sv
test/tb_hsv_to_rgb_converter.sv
